// ===== hdl/efrs_pkg.sv =====
// Package for the earliest-free-room scheduler.
// Holds the shared widths, the controller state type and the structs that pass
// between the top level and the room cells. It depends on nothing.
package efrs_pkg;

  localparam int MAX_ROOMS = 16;
  localparam int ROOM_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // Running minimum handed from one cell to the next.
  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] value;
    logic [ROOM_W-1:0] index;
  } cand_t;

  // Update broadcast to every cell when a job's result is issued.
  typedef struct packed {
    logic              en;
    logic              clr;
    logic [ROOM_W-1:0] index;
    logic [TIME_W-1:0] value;
  } room_wr_t;

endpackage

// ===== hdl/efrs_cell.sv =====
// One room cell of the scheduler: holds that room's end time and forwards the
// running (earliest end, room) pair to its neighbor every cycle.
// Depends on efrs_pkg.
module efrs_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [efrs_pkg::ROOM_W-1:0]   cell_index,
  input  efrs_pkg::room_wr_t            wr,
  input  efrs_pkg::cand_t               cand_in,
  output efrs_pkg::cand_t               cand_out
);

  logic [efrs_pkg::TIME_W-1:0] end_time_q;
  logic                        take;

  // A strict compare keeps the lower room number on a tie.
  assign take = !cand_in.found || (end_time_q < cand_in.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      end_time_q <= '0;
    end else if (wr.clr) begin
      end_time_q <= '0;
    end else if (wr.en && (wr.index == cell_index)) begin
      end_time_q <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cand_out.found <= 1'b1;
      cand_out.value <= end_time_q;
      cand_out.index <= cell_index;
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

// ===== hdl/earliest_free_room_scheduler_top.sv =====
// Top level of the earliest-free-room scheduler: controller, output register
// and the chain of room cells. Depends on efrs_pkg and efrs_cell.
//
// Usage: room_count is written through cfg_valid/cfg_ready (always ready); the
// user must write it only while the block is idle, as the block does not
// enforce it. Values of 0 act as 1 and values above 16 act as 16.
// Each item on in_valid/in_ready carries one job duration and an is_last flag.
// Each item gives exactly one result item on out_valid/out_ready with the room,
// start time, saturated end time and the run's latest end so far.
// While a run is filling its rooms, a job needs no search: it goes from idle
// straight to the finish state, where its result is registered once the output
// register is free. Once all rooms are open, the earliest-ending room is found
// by passing a running minimum down the cell chain one cell per cycle in the
// sweep state. A new item is taken only once the last result is issued.
// An item with is_last set clears all rooms after its result is issued.
// Reset clears all room end times, the run state and the output valid flag, and
// sets room_count to 1. When the receiver stalls, the finished result waits in
// the output register; the next item is still accepted and worked on, and it
// waits only when its own result is ready and the register is still full.
module earliest_free_room_scheduler_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [efrs_pkg::COUNT_W-1:0]   room_count,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [efrs_pkg::DUR_W-1:0]     duration,
  input  logic                           is_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [efrs_pkg::ROOM_W-1:0]    room,
  output logic [efrs_pkg::TIME_W-1:0]    start_time,
  output logic [efrs_pkg::TIME_W-1:0]    end_time,
  output logic [efrs_pkg::TIME_W-1:0]    latest_end
);

  efrs_pkg::state_t             state;
  efrs_pkg::state_t             state_next;
  logic [efrs_pkg::COUNT_W-1:0] room_count_q;
  logic [efrs_pkg::COUNT_W-1:0] rooms_used;
  logic [efrs_pkg::COUNT_W-1:0] rooms_filled;
  logic [efrs_pkg::TIME_W-1:0]  run_latest;
  logic [efrs_pkg::DUR_W-1:0]   dur_q;
  logic                         last_q;
  logic                         open_q;
  logic [efrs_pkg::ROOM_W-1:0]  pick;
  logic [efrs_pkg::TIME_W-1:0]  start_q;
  logic [efrs_pkg::ROOM_W-1:0]  cnt;
  logic [efrs_pkg::ROOM_W-1:0]  last_cell;
  logic                         in_fire;
  logic                         opening;
  logic                         sweep_done;
  logic                         finish_fire;
  logic [efrs_pkg::TIME_W:0]    end_sum;
  logic [efrs_pkg::TIME_W-1:0]  end_sat;
  logic [efrs_pkg::TIME_W-1:0]  latest_new;
  efrs_pkg::cand_t              cand [efrs_pkg::MAX_ROOMS+1];
  efrs_pkg::cand_t              sweep_cand;
  efrs_pkg::room_wr_t           wr;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (room_count_q == '0) begin
      rooms_used = efrs_pkg::COUNT_W'(1);
    end else if (room_count_q > efrs_pkg::COUNT_W'(efrs_pkg::MAX_ROOMS)) begin
      rooms_used = efrs_pkg::COUNT_W'(efrs_pkg::MAX_ROOMS);
    end else begin
      rooms_used = room_count_q;
    end
  end

  assign last_cell   = efrs_pkg::ROOM_W'(rooms_used - efrs_pkg::COUNT_W'(1));
  assign in_fire     = in_valid && in_ready;
  assign opening     = rooms_filled < rooms_used;
  assign sweep_done  = (cnt == last_cell);
  assign finish_fire = (state == efrs_pkg::ST_FINISH) && (!out_valid || out_ready);

  assign end_sum    = {1'b0, start_q} + {{(efrs_pkg::TIME_W + 1 - efrs_pkg::DUR_W){1'b0}}, dur_q};
  assign end_sat    = end_sum[efrs_pkg::TIME_W] ? '1 : end_sum[efrs_pkg::TIME_W-1:0];
  assign latest_new = (end_sat > run_latest) ? end_sat : run_latest;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      efrs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = opening ? efrs_pkg::ST_FINISH : efrs_pkg::ST_SWEEP;
        end
      end
      efrs_pkg::ST_SWEEP: begin
        if (sweep_done) begin
          state_next = efrs_pkg::ST_FINISH;
        end
      end
      efrs_pkg::ST_FINISH: begin
        if (finish_fire) begin
          state_next = efrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = efrs_pkg::ST_IDLE;
      end
    endcase
  end

  // The chain head has no candidate, so cell 0 always takes its own value.
  assign cand[0]    = '0;
  assign sweep_cand = cand[rooms_used];

  assign wr.en    = finish_fire;
  assign wr.clr   = finish_fire && last_q;
  assign wr.index = pick;
  assign wr.value = end_sat;

  for (genvar g = 0; g < efrs_pkg::MAX_ROOMS; g++) begin : g_cell
    efrs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (efrs_pkg::ROOM_W'(g)),
      .wr         (wr),
      .cand_in    (cand[g]),
      .cand_out   (cand[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= efrs_pkg::ST_IDLE;
      room_count_q <= efrs_pkg::COUNT_W'(1);
      rooms_filled <= '0;
      run_latest   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        room_count_q <= room_count;
      end
      if (finish_fire) begin
        out_valid <= 1'b1;
        if (last_q) begin
          rooms_filled <= '0;
          run_latest   <= '0;
        end else begin
          run_latest <= latest_new;
          if (open_q) begin
            rooms_filled <= rooms_filled + efrs_pkg::COUNT_W'(1);
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dur_q   <= duration;
      last_q  <= is_last;
      open_q  <= opening;
      cnt     <= '0;
      pick    <= rooms_filled[efrs_pkg::ROOM_W-1:0];
      start_q <= '0;
    end else if (state == efrs_pkg::ST_SWEEP) begin
      cnt <= cnt + efrs_pkg::ROOM_W'(1);
      if (sweep_done) begin
        pick    <= sweep_cand.index;
        start_q <= sweep_cand.value;
      end
    end
    if (finish_fire) begin
      room       <= pick;
      start_time <= start_q;
      end_time   <= end_sat;
      latest_end <= latest_new;
    end
  end

endmodule
